// ===== src/stq_pkg.sv =====
package stq_pkg;

	// Queue geometry
	localparam int DEPTH       = 16;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

	// Field widths
	localparam int TIME_W = 48;
	localparam int IVL_W  = 32;
	localparam int TAG_W  = 8;
	localparam int MUL_W  = 10;
	localparam int PROD_W = IVL_W + MUL_W;

	localparam logic [MUL_W-1:0]  US_PER_MS = MUL_W'(1000);
	localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_EXPIRE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_FULL      = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EXPIRED   = 3'd4,
		ST_NONE      = 3'd5
	} status_t;

	// Ring pointer step with wrap at DEPTH
	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
		return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
	endfunction

endpackage

// ===== src/sorted_timeout_queue_unit.sv =====
// Sorted timeout queue: up to DEPTH pending timeouts kept in ascending expiry order.
// Request channel (req_valid / req_stall): action, now_us, interval_ms, tag.
// A request is taken when req_valid is high and req_stall is low. req_stall stays
// high while a request is being worked on; one request is handled at a time.
// Result channel (rsp_valid / rsp_stall): status, out_tag, last. Results leave
// through one output register; a stalled result holds until taken, and the unit
// waits in place for the register to free up before it writes the next one.
// Entries sit in a ring buffer with one write and one registered read port; a
// small sequencer walks it, one entry per cycle while shifting for an add or a remove.
// Steps per request, up to the first result being registered:
//   add:    multiply, add and saturate, read, then shift up each queued entry
//           with expiry at or after the new one; full queue: straight to the result.
//   remove: read, then scan from the head to the match and shift the entries
//           behind it (not found: read, then scan every entry).
//   expire: a read and a compare per popped entry up to the final result; with several
//           pops the first result is registered at the second pop.
//   unused action code: taken, no result.
// Reset clears the entry count and ring pointers at once; the entry storage is
// not cleared, and the unit accepts requests right after reset.
module sorted_timeout_queue_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   action,
	input  logic [stq_pkg::TIME_W-1:0]   now_us,
	input  logic [stq_pkg::IVL_W-1:0]    interval_ms,
	input  logic [stq_pkg::TAG_W-1:0]    tag,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [2:0]                   status,
	output logic [stq_pkg::TAG_W-1:0]    out_tag,
	output logic                         last
);
	import stq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_MUL,
		S_ADD_SUM,
		S_ADD_CMP,
		S_ADD_PUT,
		S_RM_RD,
		S_RM_CMP,
		S_RM_SHIFT,
		S_EX_RD,
		S_EX_CMP,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic [IDX_W-1:0]    ra_q;
	logic [IDX_W-1:0]    put_q;
	logic [IDX_W-1:0]    k_q;
	logic [NRES_W-1:0]   nres_q;
	logic                pend_q;
	logic [TAG_W-1:0]    pend_tag_q;

	logic [TIME_W-1:0]   now_q;
	logic [IVL_W-1:0]    ivl_q;
	logic [TAG_W-1:0]    tag_q;
	logic [PROD_W-1:0]   prod_q;
	logic [TIME_W-1:0]   when_q;
	status_t             res_status_q;
	logic [TAG_W-1:0]    res_tag_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic                out_last_q;

	// Entry storage and its registered read data
	logic [TIME_W-1:0]   exp_mem [DEPTH];
	logic [TAG_W-1:0]    tag_mem [DEPTH];
	logic [TIME_W-1:0]   rd_exp_q;
	logic [TAG_W-1:0]    rd_tag_q;

	logic [IDX_W-1:0]    raddr;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [TIME_W-1:0]   wexp;
	logic [TAG_W-1:0]    wtag;

	logic [TIME_W:0]     sum_c;
	logic                out_free;
	logic                out_load;
	logic                add_shift;
	logic                k_last;
	logic                rm_match;
	logic                due;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_tag   = out_tag_q;
	assign last      = out_last_q;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign sum_c     = {1'b0, now_q} + (TIME_W + 1)'(prod_q);
	assign add_shift = (rd_exp_q >= when_q);
	assign k_last    = ((CNT_W'(k_q) + 1'b1) == count_q);
	assign rm_match  = (rd_tag_q == tag_q);
	assign due       = (count_q != '0) && (nres_q < NRES_W'(MAX_RESULTS)) && (rd_exp_q < now_q);

	// Sequencer writes a new result into the output register this cycle
	assign out_load  = out_free && ((state_q == S_EMIT) ||
		((state_q == S_EX_CMP) && (!due || pend_q)));

	// Memory port control
	always_comb begin
		raddr = head_q;
		we    = 1'b0;
		waddr = put_q;
		wexp  = when_q;
		wtag  = tag_q;
		unique case (state_q)
			S_ADD_SUM: begin
				raddr = ptr_dec(tail_q);
			end
			S_ADD_CMP: begin
				// shift the examined entry up one slot, or drop the new one in above it
				we    = 1'b1;
				waddr = ptr_inc(ra_q);
				raddr = ptr_dec(ra_q);
				if (add_shift) begin
					wexp = rd_exp_q;
					wtag = rd_tag_q;
				end
			end
			S_ADD_PUT: begin
				we = 1'b1;
			end
			S_RM_CMP: begin
				raddr = ptr_inc(ra_q);
			end
			S_RM_SHIFT: begin
				we    = 1'b1;
				waddr = ptr_dec(ra_q);
				wexp  = rd_exp_q;
				wtag  = rd_tag_q;
				raddr = ptr_inc(ra_q);
			end
			default: begin
				raddr = head_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_exp_q <= exp_mem[raddr];
		rd_tag_q <= tag_mem[raddr];
		if (we) begin
			exp_mem[waddr] <= wexp;
			tag_mem[waddr] <= wtag;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			ra_q         <= '0;
			put_q        <= '0;
			k_q          <= '0;
			nres_q       <= '0;
			pend_q       <= 1'b0;
			pend_tag_q   <= '0;
			now_q        <= '0;
			ivl_q        <= '0;
			tag_q        <= '0;
			prod_q       <= '0;
			when_q       <= '0;
			res_status_q <= ST_NONE;
			res_tag_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_NONE;
			out_tag_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// output register empties once taken, unless a new result lands
			if (out_valid_q && !rsp_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						now_q <= now_us;
						ivl_q <= interval_ms;
						tag_q <= tag;
						priority case (action)
							ACT_ADD: begin
								if (count_q == CNT_W'(DEPTH)) begin
									res_status_q <= ST_FULL;
									res_tag_q    <= tag;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_ADD_MUL;
								end
							end
							ACT_REMOVE: state_q <= S_RM_RD;
							ACT_EXPIRE: begin
								nres_q  <= '0;
								pend_q  <= 1'b0;
								state_q <= S_EX_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end

				S_ADD_MUL: begin
					prod_q  <= PROD_W'(ivl_q) * PROD_W'(US_PER_MS);
					state_q <= S_ADD_SUM;
				end

				S_ADD_SUM: begin
					when_q <= sum_c[TIME_W] ? TIME_MAX : sum_c[TIME_W-1:0];
					if (count_q == '0) begin
						put_q   <= tail_q;
						state_q <= S_ADD_PUT;
					end else begin
						ra_q    <= ptr_dec(tail_q);
						k_q     <= IDX_W'(count_q - 1'b1);
						state_q <= S_ADD_CMP;
					end
				end

				S_ADD_CMP: begin
					// walk down from the tail while entries expire at or after the new one
					if (add_shift) begin
						if (k_q == '0) begin
							put_q   <= ra_q;
							state_q <= S_ADD_PUT;
						end else begin
							ra_q <= ptr_dec(ra_q);
							k_q  <= k_q - 1'b1;
						end
					end else begin
						count_q      <= count_q + 1'b1;
						tail_q       <= ptr_inc(tail_q);
						res_status_q <= ST_ADDED;
						res_tag_q    <= tag_q;
						state_q      <= S_EMIT;
					end
				end

				S_ADD_PUT: begin
					count_q      <= count_q + 1'b1;
					tail_q       <= ptr_inc(tail_q);
					res_status_q <= ST_ADDED;
					res_tag_q    <= tag_q;
					state_q      <= S_EMIT;
				end

				S_RM_RD: begin
					res_tag_q <= tag_q;
					if (count_q == '0) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_EMIT;
					end else begin
						ra_q    <= head_q;
						k_q     <= '0;
						state_q <= S_RM_CMP;
					end
				end

				S_RM_CMP: begin
					// scan from the head for the first matching tag
					if (rm_match && k_last) begin
						count_q      <= count_q - 1'b1;
						tail_q       <= ptr_dec(tail_q);
						res_status_q <= ST_REMOVED;
						state_q      <= S_EMIT;
					end else if (!rm_match && k_last) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_EMIT;
					end else begin
						ra_q <= ptr_inc(ra_q);
						k_q  <= k_q + 1'b1;
						if (rm_match) begin
							state_q <= S_RM_SHIFT;
						end
					end
				end

				S_RM_SHIFT: begin
					// close the gap: each later entry moves down one slot
					if (k_last) begin
						count_q      <= count_q - 1'b1;
						tail_q       <= ptr_dec(tail_q);
						res_status_q <= ST_REMOVED;
						state_q      <= S_EMIT;
					end else begin
						ra_q <= ptr_inc(ra_q);
						k_q  <= k_q + 1'b1;
					end
				end

				S_EX_RD: begin
					state_q <= S_EX_CMP;
				end

				S_EX_CMP: begin
					// one popped tag is held back until we know whether it is the last
					if (due) begin
						if (!pend_q || out_free) begin
							if (pend_q) begin
								out_valid_q  <= 1'b1;
								out_status_q <= ST_EXPIRED;
								out_tag_q    <= pend_tag_q;
								out_last_q   <= 1'b0;
							end
							pend_q     <= 1'b1;
							pend_tag_q <= rd_tag_q;
							nres_q     <= nres_q + 1'b1;
							head_q     <= ptr_inc(head_q);
							count_q    <= count_q - 1'b1;
							state_q    <= S_EX_RD;
						end
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= pend_q ? ST_EXPIRED : ST_NONE;
						out_tag_q    <= pend_q ? pend_tag_q : '0;
						out_last_q   <= 1'b1;
						pend_q       <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_tag_q    <= res_tag_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
